>>> rtl/bbit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box interference test: shared definitions
// Coordinate widths, stream packing offsets, register indexes, query kinds
// and relation codes used by the datapath and its checker.
// ----------------------------------------------------------------------------
package bbit_pkg;

  // Coordinates are signed Q16.8; the radius is unsigned and one bit narrower.
  localparam int COORD_WIDTH = 24;
  localparam int RADIUS_W    = COORD_WIDTH - 1;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int SQ_W        = 2 * COORD_WIDTH;
  localparam int R2_W        = 2 * RADIUS_W;
  localparam int SUM_W       = SQ_W + 2;

  // Stream packing.
  localparam int IN_BITS      = 6 * COORD_WIDTH + RADIUS_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int RADIUS_LSB   = 6 * COORD_WIDTH;
  localparam int OPCODE_W     = 2;
  localparam int REL_W        = 2;
  localparam int OUT_TDATA_W  = 8;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Z = 3'd5;

  // Query kinds.
  localparam logic [OPCODE_W-1:0] OP_BOX    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SPHERE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_POINT  = 2'd2;

  // Relation codes.
  localparam logic [REL_W-1:0] REL_NONE     = 2'd0;
  localparam logic [REL_W-1:0] REL_COLLIDES = 2'd1;
  localparam logic [REL_W-1:0] REL_CONTAINS = 2'd2;
  localparam logic [REL_W-1:0] REL_UNUSED   = 2'd3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [RADIUS_W-1:0]           radius_t;
  typedef logic [COORD_WIDTH-1:0]        dist_t;
  typedef logic [SQ_W-1:0]               sq_t;
  typedef logic [R2_W-1:0]               r2_t;
  typedef logic [SUM_W-1:0]              sum_t;

endpackage

>>> rtl/bounding_box_interference_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box interference test
// Classifies box, sphere and point queries against a reference box.
// ----------------------------------------------------------------------------
// The block takes one query per clock while the result side does not stall
// and returns one relation per query, in order. A query passes five register
// stages (input, classify, square, sum, output) before its relation appears
// on the output. Throughput is one query per clock when the result side does
// not stall, set by the fully pipelined datapath; each stage holds its item
// only while the stage after it is full and stalled, so bubbles are squeezed
// out and input transfers continue while a result waits. Reference box
// registers are written through the cfg port; the user must write them only
// while no query is in flight, as the block itself does not enforce it.
module bounding_box_interference_test_top
  import bbit_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data,
  // Query stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata, low to high: first_x, first_y, first_z, second_x, second_y,
  // second_z, radius, zero pad.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: opcode.
  input  logic [OPCODE_W-1:0]    in_tuser,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata, low to high: relation, zero pad.
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Reference box registers.
  coord_t low_r  [3];
  coord_t high_r [3];

  // Stage 1: registered query.
  logic          v1_r;
  logic [OPCODE_W-1:0] op1_r;
  coord_t        c1_r [3];
  coord_t        q1_r [3];
  radius_t       rad1_r;

  // Stage 2: classified query and per-axis distance outside the box.
  logic          v2_r;
  logic [REL_W-1:0] rel2_r;
  logic          sph2_r;
  dist_t         dist2_r [3];
  radius_t       rad2_r;

  // Stage 3: squares.
  logic          v3_r;
  logic [REL_W-1:0] rel3_r;
  logic          sph3_r;
  sq_t           sq3_r [3];
  r2_t           r2_3_r;

  // Stage 4: squared distance sum.
  logic          v4_r;
  logic [REL_W-1:0] rel4_r;
  logic          sph4_r;
  sum_t          sum4_r;
  r2_t           r2_4_r;

  // Stage 5: output register.
  logic          v5_r;
  logic [REL_W-1:0] rel5_r;

  // Stage load enables: a stage takes new data when empty or when it drains.
  logic en1, en2, en3, en4, en5;

  // Stage 2 combinational results.
  logic [2:0]       pt_in;
  logic [2:0]       box_in;
  logic [2:0]       box_ov;
  logic [2:0]       face_ok;
  logic [REL_W-1:0] rel2_nxt;
  logic             sph2_nxt;
  dist_t            dist2_nxt [3];
  logic signed [DIFF_W-1:0] d_lo [3];
  logic signed [DIFF_W-1:0] d_hi [3];

  // Stage 3 and 4 combinational results.
  sq_t              sq3_nxt [3];
  r2_t              r2_3_nxt;
  sum_t             sum4_nxt;
  logic [REL_W-1:0] rel5_nxt;

  assign en5 = !v5_r || out_tready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        low_r[i]  <= '0;
        high_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_LOW_X:  low_r[0]  <= cfg_data;
        CFG_BOX_LOW_Y:  low_r[1]  <= cfg_data;
        CFG_BOX_LOW_Z:  low_r[2]  <= cfg_data;
        CFG_BOX_HIGH_X: high_r[0] <= cfg_data;
        CFG_BOX_HIGH_Y: high_r[1] <= cfg_data;
        CFG_BOX_HIGH_Z: high_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 1: capture the query fields.
  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r  <= in_tuser;
      rad1_r <= in_tdata[RADIUS_LSB +: RADIUS_W];
      for (int i = 0; i < 3; i++) begin
        c1_r[i] <= in_tdata[i*COORD_WIDTH +: COORD_WIDTH];
        q1_r[i] <= in_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH];
      end
    end
  end

  // Stage 2: interval tests per axis and the distance outside the box.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt_in[i]  = (low_r[i] <= c1_r[i]) && (c1_r[i] <= high_r[i]);
      box_in[i] = (low_r[i] <= c1_r[i]) && (q1_r[i] <= high_r[i]);
      box_ov[i] = !((high_r[i] < c1_r[i]) || (low_r[i] > q1_r[i]));
      d_lo[i]   = DIFF_W'(c1_r[i]) - DIFF_W'(low_r[i]);
      d_hi[i]   = DIFF_W'(high_r[i]) - DIFF_W'(c1_r[i]);
      // Both face distances are non-negative whenever the center is inside.
      face_ok[i] = ($unsigned(d_lo[i]) >= {2'b00, rad1_r}) &&
                   ($unsigned(d_hi[i]) >= {2'b00, rad1_r});
      if (c1_r[i] < low_r[i]) begin
        dist2_nxt[i] = dist_t'(-d_lo[i]);
      end else if (c1_r[i] > high_r[i]) begin
        dist2_nxt[i] = dist_t'(-d_hi[i]);
      end else begin
        dist2_nxt[i] = '0;
      end
    end
    sph2_nxt = 1'b0;
    case (op1_r)
      OP_BOX: begin
        if (&box_in)      rel2_nxt = REL_CONTAINS;
        else if (&box_ov) rel2_nxt = REL_COLLIDES;
        else              rel2_nxt = REL_NONE;
      end
      OP_SPHERE: begin
        if ((&pt_in) && (&face_ok)) begin
          rel2_nxt = REL_CONTAINS;
        end else begin
          // Decided later by the squared distance test.
          rel2_nxt = REL_NONE;
          sph2_nxt = 1'b1;
        end
      end
      OP_POINT: rel2_nxt = (&pt_in) ? REL_CONTAINS : REL_NONE;
      default:  rel2_nxt = REL_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      rel2_r <= rel2_nxt;
      sph2_r <= sph2_nxt;
      rad2_r <= rad1_r;
      for (int i = 0; i < 3; i++) begin
        dist2_r[i] <= dist2_nxt[i];
      end
    end
  end

  // Stage 3: square the distances and the radius.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq3_nxt[i] = SQ_W'(dist2_r[i]) * SQ_W'(dist2_r[i]);
    end
    r2_3_nxt = R2_W'(rad2_r) * R2_W'(rad2_r);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      rel3_r <= rel2_r;
      sph3_r <= sph2_r;
      r2_3_r <= r2_3_nxt;
      for (int i = 0; i < 3; i++) begin
        sq3_r[i] <= sq3_nxt[i];
      end
    end
  end

  // Stage 4: exact sum of the squared distances (cannot overflow).
  assign sum4_nxt = SUM_W'(sq3_r[0]) + SUM_W'(sq3_r[1]) + SUM_W'(sq3_r[2]);

  always_ff @(posedge clk) begin
    if (en4) begin
      rel4_r <= rel3_r;
      sph4_r <= sph3_r;
      r2_4_r <= r2_3_r;
      sum4_r <= sum4_nxt;
    end
  end

  // Stage 5: resolve the sphere collision test into the output register.
  always_comb begin
    if (sph4_r) begin
      rel5_nxt = (sum4_r <= SUM_W'(r2_4_r)) ? REL_COLLIDES : REL_NONE;
    end else begin
      rel5_nxt = rel4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      rel5_r <= rel5_nxt;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {{(OUT_TDATA_W-REL_W){1'b0}}, rel5_r};

endmodule

>>> rtl/bbit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding box interference test: port checker
// Watches the top level ports for flow control and result code violations.
// ----------------------------------------------------------------------------
module bbit_checker
  import bbit_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // No result is presented right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // The pipeline can always take a query when the output side can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled while output can drain");

  // Only the three defined relation codes are ever produced, with a zero pad.
  a_rel_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[REL_W-1:0] != REL_UNUSED &&
                   out_tdata[OUT_TDATA_W-1:REL_W] == '0)
    else $error("undefined relation code");

endmodule

bind bounding_box_interference_test_top bbit_checker u_bbit_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
